// ----- rtl/core/pidfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pidfd_pkg
// shared widths, register indexes, command codes and the step table for the
// filtered-derivative pid core
// ----------------------------------------------------------------------------
`default_nettype none

package pidfd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd6;

    localparam logic [23:0]        SAMPLE_PERIOD_RST = 24'd65;
    localparam logic signed [15:0] OUTPUT_MIN_RST    = 16'sh8000;
    localparam logic signed [15:0] OUTPUT_MAX_RST    = 16'sh7fff;

    // coefficient divider
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 26;
    localparam int DIV_CNT_W = 6;

    // multiplier operand selects
    localparam logic [2:0] MUL_KI_DT   = 3'd0;
    localparam logic [2:0] MUL_KP_E    = 3'd1;
    localparam logic [2:0] MUL_KIDT_LO = 3'd2;
    localparam logic [2:0] MUL_KIDT_HI = 3'd3;
    localparam logic [2:0] MUL_B_LO    = 3'd4;
    localparam logic [2:0] MUL_B_HI    = 3'd5;
    localparam logic [2:0] MUL_DACC_LO = 3'd6;
    localparam logic [2:0] MUL_DACC_HI = 3'd7;

    // accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // result stores
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_KIDT  = 3'd1;
    localparam logic [2:0] ST_P     = 3'd2;
    localparam logic [2:0] ST_INT   = 3'd3;
    localparam logic [2:0] ST_DER   = 3'd4;
    localparam logic [2:0] ST_CLAMP = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam int                SEQ_STEP_W = 4;
    localparam logic [SEQ_STEP_W-1:0] SEQ_LAST = 4'd11;

    typedef struct packed {
        logic       load_in;
        logic       div_start;
        logic       div_sel_b;
        logic       store_a;
        logic       store_b;
        logic [2:0] mul_sel;
        logic [1:0] acc_op;
        logic       acc_sh24;
        logic [2:0] store_op;
    } pidfd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic coef_stale;
    } pidfd_status_t;

    // step table: a product issued in step k is accumulated in step k+1,
    // stores read the accumulator as it stands at the start of the step
    function automatic pidfd_cmd_t seq_cmd(input logic [SEQ_STEP_W-1:0] step);
        pidfd_cmd_t c;
        c = '0;
        case (step)
            4'd0: begin
                c.mul_sel = MUL_KI_DT;
            end
            4'd1: begin
                c.mul_sel = MUL_KP_E;
                c.acc_op  = ACC_LOAD;
            end
            4'd2: begin
                c.acc_op   = ACC_LOAD;
                c.store_op = ST_KIDT;
            end
            4'd3: begin
                c.mul_sel  = MUL_KIDT_LO;
                c.store_op = ST_P;
            end
            4'd4: begin
                c.mul_sel = MUL_KIDT_HI;
                c.acc_op  = ACC_LOAD;
            end
            4'd5: begin
                c.mul_sel  = MUL_B_LO;
                c.acc_op   = ACC_ADD;
                c.acc_sh24 = 1'b1;
            end
            4'd6: begin
                c.mul_sel  = MUL_B_HI;
                c.acc_op   = ACC_LOAD;
                c.store_op = ST_INT;
            end
            4'd7: begin
                c.mul_sel  = MUL_DACC_LO;
                c.acc_op   = ACC_ADD;
                c.acc_sh24 = 1'b1;
            end
            4'd8: begin
                c.mul_sel = MUL_DACC_HI;
                c.acc_op  = ACC_ADD;
            end
            4'd9: begin
                c.acc_op   = ACC_ADD;
                c.acc_sh24 = 1'b1;
            end
            4'd10: begin
                c.store_op = ST_DER;
            end
            4'd11: begin
                c.store_op = ST_CLAMP;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pidfd_div.sv -----
// ----------------------------------------------------------------------------
// pidfd_div
// restoring divider, one quotient bit per cycle, for the derivative filter
// coefficients
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_div (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             start,
    input  wire [pidfd_pkg::DIV_NUM_W-1:0]  num,
    input  wire [pidfd_pkg::DIV_DEN_W-1:0]  den,
    output logic                            done,
    output logic [pidfd_pkg::DIV_NUM_W-1:0] quo
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [pidfd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [pidfd_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [pidfd_pkg::DIV_DEN_W-1:0] den_reg;
    logic [pidfd_pkg::DIV_NUM_W-1:0] nq_reg;
    logic [pidfd_pkg::DIV_DEN_W:0]   trial;
    logic [pidfd_pkg::DIV_DEN_W:0]   trial_sub;
    logic                            qbit;

    // shift in the next numerator bit and try the subtraction
    always_comb begin
        trial     = {rem_reg, nq_reg[pidfd_pkg::DIV_NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= pidfd_pkg::DIV_CNT_W'(pidfd_pkg::DIV_NUM_W - 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            rem_reg <= qbit ? trial_sub[pidfd_pkg::DIV_DEN_W-1:0]
                            : trial[pidfd_pkg::DIV_DEN_W-1:0];
            nq_reg  <= {nq_reg[pidfd_pkg::DIV_NUM_W-2:0], qbit};
        end else if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            nq_reg  <= num;
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pidfd_datapath.sv -----
// ----------------------------------------------------------------------------
// pidfd_datapath
// configuration registers, loop state, shared multiplier and accumulator,
// coefficient divider and the clamp and rounding logic
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_datapath (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire [pidfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [pidfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire signed [15:0]                s_target,
    input  wire signed [15:0]                s_sensed,
    input  pidfd_pkg::pidfd_cmd_t            cmd,
    output pidfd_pkg::pidfd_status_t         status,
    output logic signed [15:0]               m_drive
);

    localparam logic signed [52:0] S48_MAX  = 53'sd140737488355327;
    localparam logic signed [52:0] S48_MIN  = -53'sd140737488355328;
    localparam logic signed [65:0] SUM_HI   = 66'sd4611686018427387904;
    localparam logic signed [65:0] SUM_LO   = -66'sd4611686018427387904;
    localparam logic signed [34:0] DRV_MAX  = 35'sd32767;
    localparam logic signed [34:0] DRV_MIN  = -35'sd32768;

    // configuration
    logic [23:0]        prop_gain_reg;
    logic [23:0]        integral_gain_reg;
    logic [23:0]        deriv_gain_reg;
    logic [23:0]        tau_reg;
    logic [23:0]        period_reg;
    logic signed [15:0] out_min_reg;
    logic signed [15:0] out_max_reg;
    logic               stale_reg;

    // item and loop state
    logic signed [15:0] target_reg;
    logic signed [15:0] sensed_reg;
    logic signed [16:0] last_error_reg;
    logic signed [15:0] last_sensed_reg;
    logic signed [47:0] integ_reg;
    logic signed [47:0] deriv_reg;

    // intermediates
    logic signed [16:0]                 a_reg;
    logic [pidfd_pkg::DIV_NUM_W-1:0]    b_reg;
    logic [32:0]                        kidt_reg;
    logic signed [40:0]                 p_reg;
    logic signed [49:0]                 prod_reg;
    logic signed [65:0]                 acc_reg;
    logic signed [15:0]                 drive_reg;

    logic signed [16:0] err;
    logic signed [16:0] dm;
    logic signed [17:0] esum;
    logic [23:0]        dt_eff;
    logic [24:0]        tau2;
    logic [pidfd_pkg::DIV_DEN_W-1:0] den;
    logic signed [26:0] diff_a;
    logic               a_neg;
    logic [26:0]        mag_a;
    logic [pidfd_pkg::DIV_NUM_W-1:0] num_a;
    logic [pidfd_pkg::DIV_NUM_W-1:0] num_b;
    logic [pidfd_pkg::DIV_NUM_W-1:0] div_num;
    logic [pidfd_pkg::DIV_NUM_W-1:0] div_quo;
    logic               div_done;
    logic [15:0]        a_mag;
    logic signed [16:0] a_new;

    logic signed [24:0] mul_x;
    logic signed [24:0] mul_y;
    logic signed [65:0] prod_ext;
    logic signed [65:0] prod_sh;

    logic [48:0]        kidt_sum;
    logic signed [50:0] isum;
    logic signed [51:0] isum_p1;
    logic signed [50:0] inc;
    logic signed [52:0] int_sum;
    logic signed [47:0] int_new;

    logic signed [63:0] dclamp;
    logic signed [64:0] dsum;
    logic signed [47:0] dround;
    logic signed [47:0] deriv_new;

    logic signed [41:0] hi_q42;
    logic signed [41:0] lo_q42;
    logic signed [41:0] p42;
    logic signed [41:0] lim_hi;
    logic signed [41:0] lim_lo;
    logic signed [47:0] lim_hi48;
    logic signed [47:0] lim_lo48;
    logic signed [47:0] int_clamped;

    logic signed [49:0] total;
    logic signed [49:0] hi_q50;
    logic signed [49:0] lo_q50;
    logic signed [49:0] total_cl;
    logic signed [50:0] rsum;
    logic signed [34:0] rval;
    logic signed [15:0] drive_new;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integral_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            tau_reg           <= '0;
            period_reg        <= pidfd_pkg::SAMPLE_PERIOD_RST;
            out_min_reg       <= pidfd_pkg::OUTPUT_MIN_RST;
            out_max_reg       <= pidfd_pkg::OUTPUT_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pidfd_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata;
                pidfd_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_wdata;
                pidfd_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_wdata;
                pidfd_pkg::REG_FILTER_TC:     tau_reg           <= cfg_wdata;
                pidfd_pkg::REG_SAMPLE_PERIOD: period_reg        <= cfg_wdata;
                pidfd_pkg::REG_OUTPUT_MIN:    out_min_reg       <= $signed(cfg_wdata[15:0]);
                pidfd_pkg::REG_OUTPUT_MAX:    out_max_reg       <= $signed(cfg_wdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    // filter coefficients need recomputing after kd, tau or dt change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg <= 1'b1;
        end else if (cfg_we && (cfg_index == pidfd_pkg::REG_DERIV_GAIN ||
                                cfg_index == pidfd_pkg::REG_FILTER_TC ||
                                cfg_index == pidfd_pkg::REG_SAMPLE_PERIOD)) begin
            stale_reg <= 1'b1;
        end else if (cmd.store_b) begin
            stale_reg <= 1'b0;
        end
    end

    // item quantities and coefficient operands
    always_comb begin
        err    = $signed({target_reg[15], target_reg}) - $signed({sensed_reg[15], sensed_reg});
        dm     = $signed({sensed_reg[15], sensed_reg})
               - $signed({last_sensed_reg[15], last_sensed_reg});
        esum   = $signed({err[16], err}) + $signed({last_error_reg[16], last_error_reg});
        dt_eff = (period_reg == '0) ? 24'd1 : period_reg;
        tau2   = {tau_reg, 1'b0};
        den    = {1'b0, tau2} + {2'b0, dt_eff};
        diff_a = $signed({2'b0, tau2}) - $signed({3'b0, dt_eff});
        a_neg  = diff_a[26];
        mag_a  = a_neg ? 27'(-diff_a) : diff_a;
        num_a  = {mag_a[25:0], 16'b0} + {17'b0, den[25:1]};
        num_b  = {1'b0, deriv_gain_reg, 17'b0} + {17'b0, den[25:1]};
        div_num = cmd.div_sel_b ? num_b : num_a;
        // a is held within unity
        a_mag  = (div_quo > 42'd65535) ? 16'hffff : div_quo[15:0];
        a_new  = a_neg ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
    end

    pidfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // operand select for the shared multiplier, wide values go in 24-bit limbs
    always_comb begin
        case (cmd.mul_sel)
            pidfd_pkg::MUL_KI_DT: begin
                mul_x = $signed({1'b0, integral_gain_reg});
                mul_y = $signed({1'b0, dt_eff});
            end
            pidfd_pkg::MUL_KP_E: begin
                mul_x = $signed({1'b0, prop_gain_reg});
                mul_y = $signed({{8{err[16]}}, err});
            end
            pidfd_pkg::MUL_KIDT_LO: begin
                mul_x = $signed({1'b0, kidt_reg[23:0]});
                mul_y = $signed({{7{esum[17]}}, esum});
            end
            pidfd_pkg::MUL_KIDT_HI: begin
                mul_x = $signed({16'b0, kidt_reg[32:24]});
                mul_y = $signed({{7{esum[17]}}, esum});
            end
            pidfd_pkg::MUL_B_LO: begin
                mul_x = $signed({1'b0, b_reg[23:0]});
                mul_y = $signed({{8{dm[16]}}, dm});
            end
            pidfd_pkg::MUL_B_HI: begin
                mul_x = $signed({7'b0, b_reg[41:24]});
                mul_y = $signed({{8{dm[16]}}, dm});
            end
            pidfd_pkg::MUL_DACC_LO: begin
                mul_x = $signed({1'b0, deriv_reg[23:0]});
                mul_y = $signed({{8{a_reg[16]}}, a_reg});
            end
            pidfd_pkg::MUL_DACC_HI: begin
                mul_x = $signed({deriv_reg[47], deriv_reg[47:24]});
                mul_y = $signed({{8{a_reg[16]}}, a_reg});
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        prod_ext = $signed({{16{prod_reg[49]}}, prod_reg});
        prod_sh  = cmd.acc_sh24 ? $signed({prod_ext[41:0], 24'b0}) : prod_ext;
    end

    // integrator and kidt
    always_comb begin
        kidt_sum = {1'b0, acc_reg[47:0]} + 49'd32768;
        isum     = $signed(acc_reg[50:0]);
        isum_p1  = $signed({isum[50], isum}) + 52'sd1;
        inc      = $signed(isum_p1[51:1]);
        int_sum  = $signed({{5{integ_reg[47]}}, integ_reg}) + $signed({{2{inc[50]}}, inc});
        if (int_sum > S48_MAX) begin
            int_new = S48_MAX[47:0];
        end else if (int_sum < S48_MIN) begin
            int_new = S48_MIN[47:0];
        end else begin
            int_new = int_sum[47:0];
        end
    end

    // derivative: saturate the sum, round off 16 bits, negate
    always_comb begin
        if (acc_reg > SUM_HI) begin
            dclamp = SUM_HI[63:0];
        end else if (acc_reg < SUM_LO) begin
            dclamp = SUM_LO[63:0];
        end else begin
            dclamp = acc_reg[63:0];
        end
        dsum      = $signed({dclamp[63], dclamp}) + 65'sd32768;
        dround    = $signed(dsum[63:16]);
        deriv_new = 48'sd0 - dround;
    end

    // integrator room beside the proportional term
    always_comb begin
        hi_q42   = $signed({{10{out_max_reg[15]}}, out_max_reg, 16'b0});
        lo_q42   = $signed({{10{out_min_reg[15]}}, out_min_reg, 16'b0});
        p42      = $signed({p_reg[40], p_reg});
        lim_hi   = (hi_q42 > p42) ? hi_q42 - p42 : 42'sd0;
        lim_lo   = (lo_q42 < p42) ? lo_q42 - p42 : 42'sd0;
        lim_hi48 = $signed({{6{lim_hi[41]}}, lim_hi});
        lim_lo48 = $signed({{6{lim_lo[41]}}, lim_lo});
        if (integ_reg > lim_hi48) begin
            int_clamped = lim_hi48;
        end else if (integ_reg < lim_lo48) begin
            int_clamped = lim_lo48;
        end else begin
            int_clamped = integ_reg;
        end
    end

    // output sum, clamp, round, saturate
    always_comb begin
        total  = $signed({{9{p_reg[40]}}, p_reg})
               + $signed({{2{integ_reg[47]}}, integ_reg})
               + $signed({{2{deriv_reg[47]}}, deriv_reg});
        hi_q50 = $signed({{18{out_max_reg[15]}}, out_max_reg, 16'b0});
        lo_q50 = $signed({{18{out_min_reg[15]}}, out_min_reg, 16'b0});
        if (total > hi_q50) begin
            total_cl = hi_q50;
        end else if (total < lo_q50) begin
            total_cl = lo_q50;
        end else begin
            total_cl = total;
        end
        rsum = $signed({total_cl[49], total_cl}) + 51'sd32768;
        rval = $signed(rsum[50:16]);
        if (rval > DRV_MAX) begin
            drive_new = DRV_MAX[15:0];
        end else if (rval < DRV_MIN) begin
            drive_new = DRV_MIN[15:0];
        end else begin
            drive_new = rval[15:0];
        end
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg       <= '0;
            deriv_reg       <= '0;
            last_error_reg  <= '0;
            last_sensed_reg <= '0;
        end else begin
            case (cmd.store_op)
                pidfd_pkg::ST_INT:   integ_reg <= int_new;
                pidfd_pkg::ST_DER:   deriv_reg <= deriv_new;
                pidfd_pkg::ST_CLAMP: integ_reg <= int_clamped;
                pidfd_pkg::ST_OUT: begin
                    last_error_reg  <= err;
                    last_sensed_reg <= sensed_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // payload and intermediate registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            target_reg <= s_target;
            sensed_reg <= s_sensed;
        end
        if (cmd.store_a) begin
            a_reg <= a_new;
        end
        if (cmd.store_b) begin
            b_reg <= div_quo;
        end
        prod_reg <= mul_x * mul_y;
        case (cmd.acc_op)
            pidfd_pkg::ACC_LOAD: acc_reg <= prod_sh;
            pidfd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_sh;
            default: begin
            end
        endcase
        case (cmd.store_op)
            pidfd_pkg::ST_KIDT: kidt_reg  <= kidt_sum[48:16];
            pidfd_pkg::ST_P:    p_reg     <= $signed(acc_reg[40:0]);
            pidfd_pkg::ST_OUT:  drive_reg <= drive_new;
            default: begin
            end
        endcase
    end

    assign status.div_done   = div_done;
    assign status.coef_stale = stale_reg;
    assign m_drive           = drive_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pidfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidfd_ctrl
// sequencer for one control update: coefficient divides when needed, the
// multiply-accumulate steps, and the output register handshake
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_ctrl (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    output logic                         m_valid,
    input  wire                          m_ready,
    input  pidfd_pkg::pidfd_status_t     status,
    output pidfd_pkg::pidfd_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVA = 3'd1;
    localparam logic [2:0] S_DIVB = 3'd2;
    localparam logic [2:0] S_SEQ  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [pidfd_pkg::SEQ_STEP_W-1:0] step_reg;
    logic [pidfd_pkg::SEQ_STEP_W-1:0] step_next;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic                             accept;
    logic                             out_free;

    assign accept   = s_valid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    if (status.coef_stale) begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVA;
                    end else begin
                        state_next = S_SEQ;
                    end
                end
            end
            S_DIVA: begin
                if (status.div_done) begin
                    cmd.store_a   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_b = 1'b1;
                    state_next    = S_DIVB;
                end
            end
            S_DIVB: begin
                cmd.div_sel_b = 1'b1;
                if (status.div_done) begin
                    cmd.store_b = 1'b1;
                    state_next  = S_SEQ;
                end
            end
            S_SEQ: begin
                cmd       = pidfd_pkg::seq_cmd(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == pidfd_pkg::SEQ_LAST) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold here until the previous beat has left
                if (out_free) begin
                    cmd.store_op = pidfd_pkg::ST_OUT;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.store_op == pidfd_pkg::ST_OUT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an update is in progress");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.store_op == pidfd_pkg::ST_OUT) |-> (!m_valid_reg || m_ready))
        else $error("output register written while full");

    // divider completion only expected while waiting for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == S_DIVA || state_reg == S_DIVB))
        else $error("divider finished outside a divide state");

    // stale coefficients are always refreshed before the step sequence
    a_stale_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status.coef_stale) |=> (state_reg == S_DIVA))
        else $error("step sequence started with stale coefficients");

endmodule

`default_nettype wire

// ----- rtl/core/pid_filtered_derivative_clamped_core.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_derivative_clamped_core
// fixed-point pid controller with trapezoidal integrator, dynamic anti-windup,
// band-limited derivative on the measurement and clamped, rounded output
// ----------------------------------------------------------------------------
// one setpoint/measurement beat in gives one drive beat out. an update runs
// the twelve steps of the single shared 25x25 multiplier and its accumulator
// and writes the output register once the previous result has left; only
// then is the next beat accepted. after reset and after any write to
// deriv_gain, filter_time_constant or sample_period the next update first
// recomputes the two filter coefficients on the restoring divider, one
// quotient bit per cycle for two 42-bit quotients. gains, tau and dt are
// unsigned q8.16; the integrator and derivative states are q32.16; drive is
// rounded half up and clamped to [output_min, output_max], the upper limit
// tested first when the limits are reversed. a zero sample_period acts as one
// lsb. the output register lets a new beat be accepted while the previous
// result still waits for m_ready. the user must see that configuration is
// written only while no update is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_filtered_derivative_clamped_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration write port
    input  wire                              cfg_we,
    input  wire [pidfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [pidfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample beat
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire signed [15:0]                s_target,
    input  wire signed [15:0]                s_sensed,
    // drive beat
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [15:0]               m_drive
);

    // command and status between sequencer and datapath
    pidfd_pkg::pidfd_cmd_t    cmd;
    pidfd_pkg::pidfd_status_t status;

    // sequencer: divides when coefficients are stale, then the mac steps
    pidfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: registers, multiplier, divider, clamps and output register
    pidfd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_target  (s_target),
        .s_sensed  (s_sensed),
        .cmd       (cmd),
        .status    (status),
        .m_drive   (m_drive)
    );

endmodule

`default_nettype wire

// ----- bench/tb_pid_filtered_derivative_clamped_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_filtered_derivative_clamped_core
// self-checking bench for the filtered-derivative pid core: a queue-fed beat
// driver and a drive monitor run against a cycle-free fixed-point predictor
// of the control law. directed beats cover field extremes, a zero sample
// period, reversed limits and the filter coefficient at its limits. random
// phases then change gains, tau, dt and limits between drained runs, under
// several idling patterns and one long receiver hold-off
// ----------------------------------------------------------------------------

module tb_pid_filtered_derivative_clamped_core;

    // fixed-point constants of the control law
    localparam longint Q_ONE     = 64'sd65536;
    localparam longint ACC48_MAX = 64'sd140737488355327;
    localparam longint ACC48_MIN = -ACC48_MAX - 1;
    localparam longint SUM_CAP   = 64'sd4611686018427387904;

    // run shape
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 180;
    localparam int PRESSURE_BEATS = 90;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] sensed;
    } sample_t;

    // clock, reset and every block input start at a known value
    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [pidfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pidfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    logic signed [15:0]               s_target  = '0;
    logic signed [15:0]               s_sensed  = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    logic signed [15:0]               m_drive;

    // beats waiting to be offered, and drive values waiting to come back
    sample_t            sample_backlog[$];
    logic signed [15:0] drive_expected[$];

    // idling percentages, per cycle, for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off, counted in the receiver process
    bit hold_go    = 1'b0;
    int hold_count = 0;

    int mismatches  = 0;
    int drive_beats = 0;

    // predictor copy of the registers, at their reset values
    longint kp_cfg        = 0;
    longint ki_cfg        = 0;
    longint kd_cfg        = 0;
    longint tau_cfg       = 0;
    longint period_cfg    = 65;
    longint drive_min_cfg = -32768;
    longint drive_max_cfg = 32767;

    // predictor copy of the loop state, reset to zero
    longint integ_state = 0;
    longint deriv_state = 0;
    longint held_error  = 0;
    longint prev_sensed = 0;

    pid_filtered_derivative_clamped_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_target  (s_target),
        .s_sensed  (s_sensed),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_drive   (m_drive)
    );

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // add half an lsb, then arithmetic shift (floor)
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // divide rounding half away from zero, den always positive
    function automatic longint div_nearest(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clip48(input longint v);
        if (v > ACC48_MAX)
            return ACC48_MAX;
        if (v < ACC48_MIN)
            return ACC48_MIN;
        return v;
    endfunction

    // one controller update: moves the loop state on, returns the drive value
    function automatic logic signed [15:0] advance_loop(input sample_t smp);
        longint err, dm, dt, tau2, p, kidt, den, a, b, x, y, acc;
        longint hi_q, lo_q, lim_hi, lim_lo, total, r;
        err  = longint'(smp.target) - longint'(smp.sensed);
        dm   = longint'(smp.sensed) - prev_sensed;
        // a zero sample period counts as one lsb
        dt   = (period_cfg == 0) ? 64'sd1 : period_cfg;
        tau2 = 2 * tau_cfg;
        p    = kp_cfg * err;

        // trapezoidal integrator, ki*dt rounded to q.16 first
        kidt = (ki_cfg * dt + 32768) >>> 16;
        integ_state = clip48(integ_state + round_shift(kidt * (err + held_error), 1));

        // band-limited derivative on the measurement
        den = tau2 + dt;
        a   = div_nearest((tau2 - dt) * Q_ONE, den);
        // coefficient kept just short of unity
        if (a > 65535)
            a = 65535;
        else if (a < -65535)
            a = -65535;
        b = div_nearest(kd_cfg * 2 * Q_ONE, den);
        x = b * dm;
        y = a * deriv_state;
        // saturating sum, checked before the add can wrap
        if (y > 0 && x > SUM_CAP - y) begin
            acc = SUM_CAP;
        end else if (y < 0 && x < -SUM_CAP - y) begin
            acc = -SUM_CAP;
        end else begin
            acc = x + y;
            if (acc > SUM_CAP)
                acc = SUM_CAP;
            else if (acc < -SUM_CAP)
                acc = -SUM_CAP;
        end
        deriv_state = clip48(-round_shift(acc, 16));

        // integrator room beside the proportional term
        hi_q   = drive_max_cfg * Q_ONE;
        lo_q   = drive_min_cfg * Q_ONE;
        lim_hi = (hi_q > p) ? hi_q - p : 64'sd0;
        lim_lo = (lo_q < p) ? lo_q - p : 64'sd0;
        if (integ_state > lim_hi)
            integ_state = lim_hi;
        else if (integ_state < lim_lo)
            integ_state = lim_lo;

        // output clamp, upper limit first so reversed limits follow suit
        total = p + integ_state + deriv_state;
        if (total > hi_q)
            total = hi_q;
        else if (total < lo_q)
            total = lo_q;
        r = round_shift(total, 16);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;

        held_error  = err;
        prev_sensed = longint'(smp.sensed);
        return r[15:0];
    endfunction

    // ------------------------------------------------------------------
    // sample driver: offers queued beats, predicts on every accepted beat
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : sample_driver
        sample_t taken;
        sample_t next_smp;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken = '{target: s_target, sensed: s_sensed};
                drive_expected.push_back(advance_loop(taken));
            end
            // the slot frees up when nothing is held or the held beat just went
            if (!s_valid || s_ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_smp = sample_backlog.pop_front();
                    s_valid  <= 1'b1;
                    s_target <= next_smp.target;
                    s_sensed <= next_smp.sensed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge aclk) begin : drive_receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && hold_count < HOLD_CYCLES) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // drive monitor: every accepted beat against the oldest prediction
    always @(posedge aclk) begin : drive_monitor
        logic signed [15:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expected.size() == 0) begin
                report_mismatch($sformatf("drive beat %0d (%0d) with nothing expected",
                                          drive_beats, m_drive));
            end else begin
                want = drive_expected.pop_front();
                if (m_drive !== want)
                    report_mismatch($sformatf("drive beat %0d: got %0d, want %0d",
                                              drive_beats, m_drive, want));
            end
            drive_beats++;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register write, mirrored into the predictor in the same step
    task automatic write_reg(input logic [pidfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidfd_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pidfd_pkg::REG_PROP_GAIN:     kp_cfg        = longint'(val);
            pidfd_pkg::REG_INTEGRAL_GAIN: ki_cfg        = longint'(val);
            pidfd_pkg::REG_DERIV_GAIN:    kd_cfg        = longint'(val);
            pidfd_pkg::REG_FILTER_TC:     tau_cfg       = longint'(val);
            pidfd_pkg::REG_SAMPLE_PERIOD: period_cfg    = longint'(val);
            pidfd_pkg::REG_OUTPUT_MIN:    drive_min_cfg = longint'($signed(val[15:0]));
            pidfd_pkg::REG_OUTPUT_MAX:    drive_max_cfg = longint'($signed(val[15:0]));
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_loop(input logic [23:0] kp, input logic [23:0] ki,
                                input logic [23:0] kd, input logic [23:0] tau,
                                input logic [23:0] dt);
        write_reg(pidfd_pkg::REG_PROP_GAIN, kp);
        write_reg(pidfd_pkg::REG_INTEGRAL_GAIN, ki);
        write_reg(pidfd_pkg::REG_DERIV_GAIN, kd);
        write_reg(pidfd_pkg::REG_FILTER_TC, tau);
        write_reg(pidfd_pkg::REG_SAMPLE_PERIOD, dt);
    endtask

    task automatic write_limits(input logic signed [15:0] lo, input logic signed [15:0] hi);
        write_reg(pidfd_pkg::REG_OUTPUT_MIN, {{8{lo[15]}}, lo});
        write_reg(pidfd_pkg::REG_OUTPUT_MAX, {{8{hi[15]}}, hi});
    endtask

    task automatic offer(input logic signed [15:0] tgt, input logic signed [15:0] sns);
        sample_backlog.push_back('{target: tgt, sensed: sns});
    endtask

    // wait until every queued beat is in and every drive value is back
    task automatic drain();
        @(negedge aclk);
        while (sample_backlog.size() != 0 || s_valid || drive_expected.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 69; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 69; end
            default: begin send_idle_pct = 25; recv_idle_pct = 25; end
        endcase
    endtask

    // gains lean towards values that keep the loop out of saturation
    function automatic logic [23:0] pick_gain();
        case ($urandom_range(7))
            0:       return 24'd0;
            1, 2, 3: return 24'($urandom_range(1, 1 << 17));
            4, 5:    return 24'($urandom_range(0, 1 << 20));
            6:       return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] extreme16();
        case ($urandom_range(3))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    task automatic program_random();
        logic [23:0]        tau, dt;
        logic signed [15:0] lo, hi, swap;
        case ($urandom_range(5))
            0:       tau = 24'd0;
            1, 2, 3: tau = 24'($urandom_range(0, 65536));
            4:       tau = 24'hffffff;
            default: tau = 24'($urandom);
        endcase
        case ($urandom_range(5))
            0:       dt = 24'd0;
            1:       dt = 24'($urandom_range(1, 64));
            2, 3:    dt = 24'($urandom_range(65, 6554));
            4:       dt = 24'hffffff;
            default: dt = 24'($urandom);
        endcase
        program_loop(pick_gain(), pick_gain(), pick_gain(), tau, dt);
        lo = 16'($urandom);
        hi = 16'($urandom);
        case ($urandom_range(9))
            0: begin
                lo = -16'sd32768;
                hi = 16'sd32767;
            end
            1: begin
                // reversed limits
                if (lo < hi) begin
                    swap = lo; lo = hi; hi = swap;
                end
            end
            default: begin
                if (lo > hi) begin
                    swap = lo; lo = hi; hi = swap;
                end
            end
        endcase
        write_limits(lo, hi);
    endtask

    // mostly a plant that drifts towards the setpoint, with setpoint steps,
    // plus some wild beats and field extremes
    task automatic queue_random(input int count);
        int plant_t, plant_s;
        plant_t = int'($urandom_range(0, 65535)) - 32768;
        plant_s = 0;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0, 1, 2: begin
                    offer(16'($urandom), 16'($urandom));
                end
                3: begin
                    offer(extreme16(), extreme16());
                end
                default: begin
                    if ($urandom_range(9) == 0)
                        plant_t = int'($urandom_range(0, 65535)) - 32768;
                    plant_s = plant_s + (plant_t - plant_s) / 8
                            + int'($urandom_range(0, 64)) - 32;
                    if (plant_s > 32767)
                        plant_s = 32767;
                    if (plant_s < -32768)
                        plant_s = -32768;
                    offer(16'(plant_t), 16'(plant_s));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: all gains zero, drive stays at zero
        offer(16'sd0, 16'sd0);
        offer(16'sd32767, -16'sd32768);
        drain();

        // unity kp and ki, light derivative, full-range limits
        program_loop(24'd65536, 24'd65536, 24'd16384, 24'd655, 24'd655);
        write_limits(-16'sd32768, 16'sd32767);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd0, 16'sd0);
        offer(16'sd1, -16'sd1);
        offer(-16'sd1, 16'sd1);
        offer(16'sd100, 16'sd50);
        offer(16'sd100, 16'sd50);
        offer(16'sd100, 16'sd50);
        drain();

        // every register at its top: filter coefficient rounds up to unity and is held just short of it
        program_loop(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'd1);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd32768, 16'sd32767);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd0, 16'sd32767);
        drain();

        // zero sample period and zero tau: coefficient held just short of minus unity
        program_loop(24'd65536, 24'd0, 24'hffffff, 24'd0, 24'd0);
        offer(16'sd0, -16'sd32768);
        offer(16'sd0, 16'sd32767);
        offer(16'sd0, 16'sd0);
        drain();

        // reversed limits, upper limit tested first
        program_loop(24'd65536, 24'd4096, 24'd0, 24'd0, 24'd65536);
        write_limits(16'sd100, -16'sd100);
        offer(16'sd1000, 16'sd0);
        offer(-16'sd1000, 16'sd0);
        offer(16'sd0, 16'sd0);
        offer(16'sd50, 16'sd0);
        drain();

        // random phases, idling pattern rotating from phase to phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idling(phase % 4);
            program_random();
            queue_random(PHASE_BEATS);
            drain();
        end

        // sender keeps offering while the receiver holds off
        set_idling(0);
        program_random();
        hold_go = 1'b1;
        queue_random(PRESSURE_BEATS);
        drain();

        if (mismatches == 0)
            $display("tb_pid_filtered_derivative_clamped_core: clean");
        else
            $display("tb_pid_filtered_derivative_clamped_core: errors");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #2000000;
        $display("tb_pid_filtered_derivative_clamped_core: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pidfd_pkg.sv
rtl/core/pidfd_div.sv
rtl/core/pidfd_datapath.sv
rtl/core/pidfd_ctrl.sv
rtl/core/pid_filtered_derivative_clamped_core.sv
bench/tb_pid_filtered_derivative_clamped_core.sv
